// File: src/abac_pkg.sv
// Package for the alpha bounding-box autocrop block.
// Holds field widths, CSR indexes, mode bit positions, the config struct and
// the pad clamp. No dependencies.
package abac_pkg;

   // Default largest frame dimension tracked
   localparam int MAX_DIM_DEFAULT = 8192;

   // Field widths
   localparam int ALPHA_W    = 13;
   localparam int THR_W      = 12;
   localparam int PAD_W      = 13;
   localparam int MODE_W     = 5;
   localparam int SIZE_W     = 14;
   localparam int MARGIN_W   = 15;
   localparam int SHIFT_W    = 27;
   localparam int SHIFT_BITS = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   // Padding is held to +/- this many pixels
   localparam int PAD_LIMIT = 4000;

   // Register reset values
   localparam logic [THR_W-1:0]  THR_RESET      = '0;
   localparam logic [MODE_W-1:0] MODE_RESET     = 5'h1F;
   localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 14'd4096;

   // Mode bit positions
   localparam int MODE_CENTER = 0;
   localparam int MODE_TOP    = 1;
   localparam int MODE_BOTTOM = 2;
   localparam int MODE_LEFT   = 3;
   localparam int MODE_RIGHT  = 4;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD  = 3'd0,
      CSR_PAD_TOP    = 3'd1,
      CSR_PAD_BOTTOM = 3'd2,
      CSR_PAD_LEFT   = 3'd3,
      CSR_PAD_RIGHT  = 3'd4,
      CSR_MODE       = 3'd5,
      CSR_MAX_WIDTH  = 3'd6,
      CSR_MAX_HEIGHT = 3'd7
   } csr_index_type;

   // Configuration registers as one bundle
   typedef struct packed {
      logic        [THR_W-1:0]  threshold;
      logic signed [PAD_W-1:0]  pad_top;
      logic signed [PAD_W-1:0]  pad_bottom;
      logic signed [PAD_W-1:0]  pad_left;
      logic signed [PAD_W-1:0]  pad_right;
      logic        [MODE_W-1:0] mode;
      logic        [SIZE_W-1:0] max_width;
      logic        [SIZE_W-1:0] max_height;
   } cfg_type;

   // Clamp a raw pad value into the legal padding range
   function automatic logic signed [PAD_W-1:0] pad_clamp(input logic signed [PAD_W-1:0] raw);
      logic signed [PAD_W-1:0] lim_hi;
      logic signed [PAD_W-1:0] lim_lo;
      lim_hi = PAD_W'(PAD_LIMIT);
      lim_lo = PAD_W'(-PAD_LIMIT);
      if (raw > lim_hi) begin
         return lim_hi;
      end else if (raw < lim_lo) begin
         return lim_lo;
      end
      return raw;
   endfunction

endpackage

// File: src/abac_track.sv
// Pixel tracker: counts columns and rows, keeps the content bounding box and
// emits a frame summary register at end of frame. Uses abac_pkg.
module abac_track #(
   parameter int MAX_DIM = abac_pkg::MAX_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [abac_pkg::ALPHA_W-1:0]     req_alpha,
   input  logic                             req_end_of_row,
   input  logic                             req_end_of_frame,
   input  logic [abac_pkg::THR_W-1:0]       threshold,
   output logic                             sum_valid,
   input  logic                             sum_ready,
   output logic [$clog2(MAX_DIM+1)-1:0]     sum_width,
   output logic [$clog2(MAX_DIM+1)-1:0]     sum_height,
   output logic [$clog2(MAX_DIM)-1:0]       sum_min_col,
   output logic [$clog2(MAX_DIM)-1:0]       sum_max_col,
   output logic [$clog2(MAX_DIM)-1:0]       sum_min_row,
   output logic [$clog2(MAX_DIM)-1:0]       sum_max_row,
   output logic                             sum_any
);
   localparam int CNTW = $clog2(MAX_DIM + 1);
   localparam int CW   = $clog2(MAX_DIM);
   localparam logic [CNTW-1:0] DIM_LIMIT = CNTW'(MAX_DIM);

   logic [CNTW-1:0] col_ff, row_ff, fw_ff;
   logic [CW-1:0]   min_col_ff, max_col_ff, min_row_ff, max_row_ff;
   logic            any_ff;
   logic            sum_valid_ff;

   logic [CNTW-1:0] col_in, frame_w, height;
   logic [CW-1:0]   col_idx, row_idx;
   logic [CW-1:0]   min_col_in, max_col_in, min_row_in, max_row_in;
   logic            accept, col_ok, row_ok, hit;

   assign req_ready = !sum_valid_ff || sum_ready;
   assign accept    = req_valid && req_ready;
   assign sum_valid = sum_valid_ff;

   // Classify the pixel and fold it into the box
   assign col_ok  = col_ff < DIM_LIMIT;
   assign row_ok  = row_ff < DIM_LIMIT;
   assign hit     = col_ok && row_ok && (req_alpha > {1'b0, threshold});
   assign col_idx = col_ff[CW-1:0];
   assign row_idx = row_ff[CW-1:0];

   assign min_col_in = (hit && col_idx < min_col_ff) ? col_idx : min_col_ff;
   assign max_col_in = (hit && col_idx > max_col_ff) ? col_idx : max_col_ff;
   assign min_row_in = (hit && row_idx < min_row_ff) ? row_idx : min_row_ff;
   assign max_row_in = (hit && row_idx > max_row_ff) ? row_idx : max_row_ff;

   // Advance the column, saturating at the frame limit
   assign col_in  = col_ok ? col_ff + CNTW'(1) : col_ff;
   assign frame_w = (col_in > fw_ff) ? col_in : fw_ff;
   assign height  = row_ok ? row_ff + CNTW'(1) : DIM_LIMIT;

   // Hold frame state; clear it when the last pixel of a frame is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         fw_ff        <= '0;
         min_col_ff   <= '1;
         max_col_ff   <= '0;
         min_row_ff   <= '1;
         max_row_ff   <= '0;
         any_ff       <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (accept && req_end_of_frame) begin
            sum_valid_ff <= 1'b1;
         end else if (sum_ready) begin
            sum_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_end_of_frame) begin
               col_ff     <= '0;
               row_ff     <= '0;
               fw_ff      <= '0;
               min_col_ff <= '1;
               max_col_ff <= '0;
               min_row_ff <= '1;
               max_row_ff <= '0;
               any_ff     <= 1'b0;
            end else begin
               min_col_ff <= min_col_in;
               max_col_ff <= max_col_in;
               min_row_ff <= min_row_in;
               max_row_ff <= max_row_in;
               any_ff     <= any_ff || hit;
               if (req_end_of_row) begin
                  fw_ff  <= frame_w;
                  col_ff <= '0;
                  row_ff <= row_ok ? row_ff + CNTW'(1) : row_ff;
               end else begin
                  col_ff <= col_in;
               end
            end
         end
      end
   end

   // Load the frame summary on the last pixel
   always_ff @(posedge clock) begin
      if (accept && req_end_of_frame) begin
         sum_width   <= frame_w;
         sum_height  <= height;
         sum_min_col <= min_col_in;
         sum_max_col <= max_col_in;
         sum_min_row <= min_row_in;
         sum_max_row <= max_row_in;
         sum_any     <= any_ff || hit;
      end
   end

endmodule

// File: src/abac_edge.sv
// Edge stage: picks each side from the box or the frame edge, adds padding,
// and registers raw margins, sizes and overshoot. Uses abac_pkg.
module abac_edge #(
   parameter int MAX_DIM = abac_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  abac_pkg::cfg_type                       cfg,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [$clog2(MAX_DIM+1)-1:0]            in_width,
   input  logic [$clog2(MAX_DIM+1)-1:0]            in_height,
   input  logic [$clog2(MAX_DIM)-1:0]              in_min_col,
   input  logic [$clog2(MAX_DIM)-1:0]              in_max_col,
   input  logic [$clog2(MAX_DIM)-1:0]              in_min_row,
   input  logic [$clog2(MAX_DIM)-1:0]              in_max_row,
   input  logic                                    in_any,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic                                    out_blank,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_left,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_top,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_right,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_bottom,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_sum_w,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_sum_h,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_over_w,
   output logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] out_over_h
);
   localparam int CNTW = $clog2(MAX_DIM + 1);
   localparam int SW   = ((CNTW > abac_pkg::PAD_W) ? CNTW : abac_pkg::PAD_W) + 3;
   localparam logic signed [SW-1:0] ZERO_S = '0;
   localparam logic signed [SW-1:0] ONE_S  = SW'(1);

   logic                 valid_ff;
   logic                 load, blank_in, searching;
   logic signed [SW-1:0] w_s, h_s, pt, pb, pl, pr;
   logic signed [SW-1:0] l_s, t_s, r_s, b_s;
   logic signed [SW-1:0] left_in, top_in, right_in, bottom_in;
   logic signed [SW-1:0] sum_w_in, sum_h_in;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;

   // Widen sizes and clamp the pads
   assign w_s = SW'(in_width);
   assign h_s = SW'(in_height);
   assign pt  = SW'(abac_pkg::pad_clamp(cfg.pad_top));
   assign pb  = SW'(abac_pkg::pad_clamp(cfg.pad_bottom));
   assign pl  = SW'(abac_pkg::pad_clamp(cfg.pad_left));
   assign pr  = SW'(abac_pkg::pad_clamp(cfg.pad_right));

   // Blank when padding swallows the frame or a search found nothing
   assign searching = cfg.mode[abac_pkg::MODE_RIGHT:abac_pkg::MODE_TOP] != '0;
   assign blank_in  = ((w_s + pl + pr) <= ZERO_S) || ((h_s + pt + pb) <= ZERO_S) ||
                      (searching && !in_any);

   // Select each side from the box or the frame edge
   assign t_s = cfg.mode[abac_pkg::MODE_TOP]    ? SW'(in_min_row) : ZERO_S;
   assign b_s = cfg.mode[abac_pkg::MODE_BOTTOM] ? SW'(in_max_row) : h_s - ONE_S;
   assign l_s = cfg.mode[abac_pkg::MODE_LEFT]   ? SW'(in_min_col) : ZERO_S;
   assign r_s = cfg.mode[abac_pkg::MODE_RIGHT]  ? SW'(in_max_col) : w_s - ONE_S;

   // Raw margins, resulting sizes and overshoot past the size limit
   assign left_in   = pl - l_s;
   assign top_in    = pt - t_s;
   assign right_in  = r_s + ONE_S - w_s + pr;
   assign bottom_in = b_s + ONE_S - h_s + pb;
   assign sum_w_in  = pl + pr + (r_s + ONE_S - l_s);
   assign sum_h_in  = pt + pb + (b_s + ONE_S - t_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_blank  <= blank_in;
         out_left   <= left_in;
         out_top    <= top_in;
         out_right  <= right_in;
         out_bottom <= bottom_in;
         out_sum_w  <= sum_w_in;
         out_sum_h  <= sum_h_in;
         out_over_w <= sum_w_in - SW'(cfg.max_width);
         out_over_h <= sum_h_in - SW'(cfg.max_height);
      end
   end

endmodule

// File: src/abac_fit.sv
// Fit stage: trims overshoot half from each side, forms sizes, blank flag and
// center shift, and holds the result register. Uses abac_pkg.
module abac_fit #(
   parameter int MAX_DIM = abac_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  abac_pkg::cfg_type                       cfg,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic                                    in_blank,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_left,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_top,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_right,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_bottom,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_sum_w,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_sum_h,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_over_w,
   input  logic signed [(($clog2(MAX_DIM+1) > abac_pkg::PAD_W) ?
                         $clog2(MAX_DIM+1) : abac_pkg::PAD_W) + 2:0] in_over_h,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_blank,
   output logic signed [abac_pkg::MARGIN_W-1:0]    rsp_margin_left,
   output logic signed [abac_pkg::MARGIN_W-1:0]    rsp_margin_top,
   output logic signed [abac_pkg::MARGIN_W-1:0]    rsp_margin_right,
   output logic signed [abac_pkg::MARGIN_W-1:0]    rsp_margin_bottom,
   output logic [abac_pkg::SIZE_W-1:0]             rsp_new_width,
   output logic [abac_pkg::SIZE_W-1:0]             rsp_new_height,
   output logic signed [abac_pkg::SHIFT_W-1:0]     rsp_center_shift_x,
   output logic signed [abac_pkg::SHIFT_W-1:0]     rsp_center_shift_y
);
   localparam int CNTW = $clog2(MAX_DIM + 1);
   localparam int SW   = ((CNTW > abac_pkg::PAD_W) ? CNTW : abac_pkg::PAD_W) + 3;
   localparam int SHL  = abac_pkg::SHIFT_W - abac_pkg::SHIFT_BITS;
   localparam logic signed [SW-1:0] ZERO_S = '0;
   localparam logic signed [SW-1:0] ONE_S  = SW'(1);

   logic                 valid_ff;
   logic                 load, over_x, over_y, blank_in, shift_on;
   logic signed [SW-1:0] cut_x, cut_y;
   logic signed [SW-1:0] left_in, right_in, top_in, bottom_in;
   logic signed [SW-1:0] width_in, height_in, diff_x, diff_y;

   assign in_ready  = !valid_ff || rsp_ready;
   assign load      = in_valid && in_ready;
   assign rsp_valid = valid_ff;

   // Trim overshoot: smaller half from left/top, larger half from right/bottom
   assign over_x    = in_over_w > ZERO_S;
   assign over_y    = in_over_h > ZERO_S;
   assign cut_x     = over_x ? in_over_w : ZERO_S;
   assign cut_y     = over_y ? in_over_h : ZERO_S;
   assign left_in   = in_left - (cut_x >>> 1);
   assign right_in  = in_right - ((cut_x + (over_x ? ONE_S : ZERO_S)) >>> 1);
   assign top_in    = in_top - (cut_y >>> 1);
   assign bottom_in = in_bottom - ((cut_y + (over_y ? ONE_S : ZERO_S)) >>> 1);
   assign width_in  = in_sum_w - cut_x;
   assign height_in = in_sum_h - cut_y;

   // Blank on an empty result size too
   assign blank_in = in_blank || (width_in <= ZERO_S) || (height_in <= ZERO_S);
   assign shift_on = !cfg.mode[abac_pkg::MODE_CENTER];
   assign diff_x   = left_in - right_in;
   assign diff_y   = top_in - bottom_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the result beat; a blank result zeroes every other field
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_blank <= blank_in;
         if (blank_in) begin
            rsp_margin_left    <= '0;
            rsp_margin_top     <= '0;
            rsp_margin_right   <= '0;
            rsp_margin_bottom  <= '0;
            rsp_new_width      <= '0;
            rsp_new_height     <= '0;
            rsp_center_shift_x <= '0;
            rsp_center_shift_y <= '0;
         end else begin
            rsp_margin_left   <= left_in[abac_pkg::MARGIN_W-1:0];
            rsp_margin_top    <= top_in[abac_pkg::MARGIN_W-1:0];
            rsp_margin_right  <= right_in[abac_pkg::MARGIN_W-1:0];
            rsp_margin_bottom <= bottom_in[abac_pkg::MARGIN_W-1:0];
            rsp_new_width     <= width_in[abac_pkg::SIZE_W-1:0];
            rsp_new_height    <= height_in[abac_pkg::SIZE_W-1:0];
            if (shift_on) begin
               rsp_center_shift_x <= {diff_x[SHL-1:0], {abac_pkg::SHIFT_BITS{1'b0}}};
               rsp_center_shift_y <= {diff_y[SHL-1:0], {abac_pkg::SHIFT_BITS{1'b0}}};
            end else begin
               rsp_center_shift_x <= '0;
               rsp_center_shift_y <= '0;
            end
         end
      end
   end

endmodule

// File: src/alpha_bbox_autocrop_top.sv
// Top level of the alpha bounding-box autocrop block: config registers and
// the tracker, edge and fit stages. Uses abac_pkg, abac_track, abac_edge, abac_fit.
//
//   channel  dir  handshake            beat
//   req_     in   req_valid/req_ready  one pixel: alpha, end_of_row, end_of_frame
//   rsp_     out  rsp_valid/rsp_ready  one crop result per frame
//   csr_     in   csr_we               one register write, index and data
//
// One pixel is accepted per cycle while req_ready is high; a frame's result passes
// through the tracker summary, the edge stage and the result register, in that order.
// Reset clears the frame counters, the bounding box and all stage valids, and
// loads the register defaults.
// A stalled result holds in the result register while the edge stage and the
// tracker summary keep taking beats; pixels stall only once all three are full.
module alpha_bbox_autocrop_top #(
   parameter int MAX_DIM = abac_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [abac_pkg::ALPHA_W-1:0]         req_alpha,
   input  logic                                 req_end_of_row,
   input  logic                                 req_end_of_frame,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_blank,
   output logic signed [abac_pkg::MARGIN_W-1:0] rsp_margin_left,
   output logic signed [abac_pkg::MARGIN_W-1:0] rsp_margin_top,
   output logic signed [abac_pkg::MARGIN_W-1:0] rsp_margin_right,
   output logic signed [abac_pkg::MARGIN_W-1:0] rsp_margin_bottom,
   output logic [abac_pkg::SIZE_W-1:0]          rsp_new_width,
   output logic [abac_pkg::SIZE_W-1:0]          rsp_new_height,
   output logic signed [abac_pkg::SHIFT_W-1:0]  rsp_center_shift_x,
   output logic signed [abac_pkg::SHIFT_W-1:0]  rsp_center_shift_y,
   input  logic                                 csr_we,
   input  logic [abac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [abac_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int CNTW = $clog2(MAX_DIM + 1);
   localparam int CW   = $clog2(MAX_DIM);
   localparam int SW   = ((CNTW > abac_pkg::PAD_W) ? CNTW : abac_pkg::PAD_W) + 3;

   abac_pkg::cfg_type cfg_ff;

   logic            sum_valid, sum_ready, sum_any;
   logic [CNTW-1:0] sum_width, sum_height;
   logic [CW-1:0]   sum_min_col, sum_max_col, sum_min_row, sum_max_row;

   logic                 edge_valid, edge_ready, edge_blank;
   logic signed [SW-1:0] edge_left, edge_top, edge_right, edge_bottom;
   logic signed [SW-1:0] edge_sum_w, edge_sum_h, edge_over_w, edge_over_h;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= abac_pkg::THR_RESET;
         cfg_ff.pad_top    <= '0;
         cfg_ff.pad_bottom <= '0;
         cfg_ff.pad_left   <= '0;
         cfg_ff.pad_right  <= '0;
         cfg_ff.mode       <= abac_pkg::MODE_RESET;
         cfg_ff.max_width  <= abac_pkg::MAX_SIZE_RESET;
         cfg_ff.max_height <= abac_pkg::MAX_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            abac_pkg::CSR_THRESHOLD:  cfg_ff.threshold  <= csr_wdata[abac_pkg::THR_W-1:0];
            abac_pkg::CSR_PAD_TOP:    cfg_ff.pad_top    <= csr_wdata[abac_pkg::PAD_W-1:0];
            abac_pkg::CSR_PAD_BOTTOM: cfg_ff.pad_bottom <= csr_wdata[abac_pkg::PAD_W-1:0];
            abac_pkg::CSR_PAD_LEFT:   cfg_ff.pad_left   <= csr_wdata[abac_pkg::PAD_W-1:0];
            abac_pkg::CSR_PAD_RIGHT:  cfg_ff.pad_right  <= csr_wdata[abac_pkg::PAD_W-1:0];
            abac_pkg::CSR_MODE:       cfg_ff.mode       <= csr_wdata[abac_pkg::MODE_W-1:0];
            abac_pkg::CSR_MAX_WIDTH:  cfg_ff.max_width  <= csr_wdata[abac_pkg::SIZE_W-1:0];
            abac_pkg::CSR_MAX_HEIGHT: cfg_ff.max_height <= csr_wdata[abac_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   abac_track #(.MAX_DIM(MAX_DIM)) u_track (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_alpha        (req_alpha),
      .req_end_of_row   (req_end_of_row),
      .req_end_of_frame (req_end_of_frame),
      .threshold        (cfg_ff.threshold),
      .sum_valid        (sum_valid),
      .sum_ready        (sum_ready),
      .sum_width        (sum_width),
      .sum_height       (sum_height),
      .sum_min_col      (sum_min_col),
      .sum_max_col      (sum_max_col),
      .sum_min_row      (sum_min_row),
      .sum_max_row      (sum_max_row),
      .sum_any          (sum_any)
   );

   abac_edge #(.MAX_DIM(MAX_DIM)) u_edge (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (sum_valid),
      .in_ready   (sum_ready),
      .in_width   (sum_width),
      .in_height  (sum_height),
      .in_min_col (sum_min_col),
      .in_max_col (sum_max_col),
      .in_min_row (sum_min_row),
      .in_max_row (sum_max_row),
      .in_any     (sum_any),
      .out_valid  (edge_valid),
      .out_ready  (edge_ready),
      .out_blank  (edge_blank),
      .out_left   (edge_left),
      .out_top    (edge_top),
      .out_right  (edge_right),
      .out_bottom (edge_bottom),
      .out_sum_w  (edge_sum_w),
      .out_sum_h  (edge_sum_h),
      .out_over_w (edge_over_w),
      .out_over_h (edge_over_h)
   );

   abac_fit #(.MAX_DIM(MAX_DIM)) u_fit (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (edge_valid),
      .in_ready           (edge_ready),
      .in_blank           (edge_blank),
      .in_left            (edge_left),
      .in_top             (edge_top),
      .in_right           (edge_right),
      .in_bottom          (edge_bottom),
      .in_sum_w           (edge_sum_w),
      .in_sum_h           (edge_sum_h),
      .in_over_w          (edge_over_w),
      .in_over_h          (edge_over_h),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_blank          (rsp_blank),
      .rsp_margin_left    (rsp_margin_left),
      .rsp_margin_top     (rsp_margin_top),
      .rsp_margin_right   (rsp_margin_right),
      .rsp_margin_bottom  (rsp_margin_bottom),
      .rsp_new_width      (rsp_new_width),
      .rsp_new_height     (rsp_new_height),
      .rsp_center_shift_x (rsp_center_shift_x),
      .rsp_center_shift_y (rsp_center_shift_y)
   );

`ifndef ASSERT_OFF
   // A blank result carries no margins and no size
   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blank |-> rsp_new_width == '0 && rsp_new_height == '0 &&
         rsp_margin_left == '0 && rsp_margin_right == '0 &&
         rsp_margin_top == '0 && rsp_margin_bottom == '0)
      else $error("blank result with nonzero fields");

   // A kept result has a nonempty size
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_blank |-> rsp_new_width != '0 && rsp_new_height != '0)
      else $error("non-blank result with zero size");

   // Center shift is a whole multiple of the shift scale
   a_shift_scaled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_shift_x[abac_pkg::SHIFT_BITS-1:0] == '0 &&
         rsp_center_shift_y[abac_pkg::SHIFT_BITS-1:0] == '0)
      else $error("center shift not scaled");

   // Nothing comes out of the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !edge_valid && !sum_valid)
      else $error("stage valid set after reset");
`endif

endmodule
